@@ rtl/fpfa_pkg.sv @@
// Shared types and constants for the fixed partition fit allocator.
// No dependencies; compiled first.

package fpfa_pkg;

   // Default geometry
   localparam int unsigned PARTITIONS_DEF = 16;
   localparam int unsigned SIZE_BITS_DEF  = 16;

   // Field widths fixed by the channel definitions
   localparam int unsigned ACTION_W  = 1;
   localparam int unsigned PINDEX_W  = 4;
   localparam int unsigned AMOUNT_W  = 16;
   localparam int unsigned OUTCOME_W = 2;
   localparam int unsigned POLICY_W  = 2;
   localparam int unsigned COUNT_W   = 5;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // Actions
   localparam logic [ACTION_W-1:0] ACT_LOAD    = 1'b0;
   localparam logic [ACTION_W-1:0] ACT_REQUEST = 1'b1;

   // Fit policies (unused code behaves as first fit)
   localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
   localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
   localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

   // Outcomes
   localparam logic [OUTCOME_W-1:0] OUT_LOADED      = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUT_ALLOCATED   = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUT_UNALLOCATED = 2'd2;

   // Register indexes (word address bit 2)
   localparam logic REG_FIT_POLICY      = 1'b0;
   localparam logic REG_PARTITION_COUNT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } fsm_state_type;

   // Commands broadcast from the controller to every cell
   typedef struct packed {
      logic load_en;   // write size, free the entry
      logic mark_en;   // set the in-use mark
   } cell_cmd_type;

endpackage

@@ rtl/fpfa_if.sv @@
// Valid/ready channel interfaces for requests and responses.
// Depends on fpfa_pkg.

interface fpfa_req_if;
   import fpfa_pkg::*;
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [PINDEX_W-1:0] partition_index;
   logic [AMOUNT_W-1:0] amount;

   modport source (output valid, action, partition_index, amount, input ready);
   modport sink   (input valid, action, partition_index, amount, output ready);
endinterface

interface fpfa_rsp_if;
   import fpfa_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [OUTCOME_W-1:0] outcome;
   logic [PINDEX_W-1:0]  chosen_index;
   logic [AMOUNT_W-1:0]  chosen_size;
   logic [AMOUNT_W-1:0]  fragment;

   modport source (output valid, outcome, chosen_index, chosen_size, fragment,
                   input ready);
   modport sink   (input valid, outcome, chosen_index, chosen_size, fragment,
                   output ready);
endinterface

@@ rtl/fpfa_csr.sv @@
// APB-style register file: fit policy and partition count.
// Depends on fpfa_pkg.

module fpfa_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [fpfa_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [fpfa_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [fpfa_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready,
   output logic [fpfa_pkg::POLICY_W-1:0]    fit_policy,
   output logic [fpfa_pkg::COUNT_W-1:0]     partition_count
);
   import fpfa_pkg::*;

   logic                wr_fire;
   logic [POLICY_W-1:0] policy_ff, policy_in;
   logic [COUNT_W-1:0]  count_ff, count_in;

   assign pready  = 1'b1;
   assign wr_fire = psel && penable && pwrite && pready;

   always_comb begin
      policy_in = policy_ff;
      count_in  = count_ff;
      if (wr_fire) begin
         case (paddr[2])
            REG_FIT_POLICY:      policy_in = pwdata[POLICY_W-1:0];
            REG_PARTITION_COUNT: count_in  = pwdata[COUNT_W-1:0];
            default:             policy_in = policy_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POL_FIRST;
         count_ff  <= '0;
      end else begin
         policy_ff <= policy_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_FIT_POLICY:      prdata = CSR_DATA_W'(policy_ff);
         REG_PARTITION_COUNT: prdata = CSR_DATA_W'(count_ff);
         default:             prdata = '0;
      endcase
   end

   assign fit_policy      = policy_ff;
   assign partition_count = count_ff;

endmodule

@@ rtl/fpfa_cell.sv @@
// One partition entry: size, in-use mark and one stage of the search chain.
// Depends on fpfa_pkg.

module fpfa_cell #(
   parameter int unsigned CELL_ID   = 0,
   parameter int unsigned IDX_W     = 4,
   parameter int unsigned SIZE_BITS = fpfa_pkg::SIZE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  fpfa_pkg::cell_cmd_type          cmd,
   input  logic [fpfa_pkg::PINDEX_W-1:0]   load_index,
   input  logic [IDX_W-1:0]                mark_index,
   input  logic [SIZE_BITS-1:0]            amount,
   input  logic [fpfa_pkg::POLICY_W-1:0]   fit_policy,
   input  logic [fpfa_pkg::COUNT_W-1:0]    partition_count,
   // search token from the previous cell
   input  logic                            prev_valid,
   input  logic                            prev_found,
   input  logic [IDX_W-1:0]                prev_idx,
   input  logic [SIZE_BITS-1:0]            prev_size,
   // search token to the next cell
   output logic                            next_valid,
   output logic                            next_found,
   output logic [IDX_W-1:0]                next_idx,
   output logic [SIZE_BITS-1:0]            next_size
);
   import fpfa_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);

   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic                 used_ff, used_in;
   logic                 valid_ff, found_ff, found_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [SIZE_BITS-1:0] best_ff, best_in;
   logic                 in_range, hit, take;

   assign in_range = CELL_ID < 32'(partition_count);
   assign hit      = prev_valid && in_range && !used_ff && (size_ff >= amount);

   always_comb begin
      take = 1'b0;
      if (hit) begin
         if (!prev_found) begin
            take = 1'b1;
         end else begin
            case (fit_policy)
               POL_BEST:  take = size_ff < prev_size;
               POL_WORST: take = size_ff > prev_size;
               default:   take = 1'b0;
            endcase
         end
      end
   end

   always_comb begin
      found_in = found_ff;
      idx_in   = idx_ff;
      best_in  = best_ff;
      if (prev_valid) begin
         found_in = prev_found || hit;
         idx_in   = take ? MY_IDX : prev_idx;
         best_in  = take ? size_ff : prev_size;
      end
   end

   always_comb begin
      size_in = size_ff;
      used_in = used_ff;
      if (cmd.load_en && (32'(load_index) == CELL_ID)) begin
         size_in = amount;
         used_in = 1'b0;
      end
      if (cmd.mark_en && (mark_index == MY_IDX)) begin
         used_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= '0;
         used_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         size_ff  <= size_in;
         used_ff  <= used_in;
         valid_ff <= prev_valid;
      end
   end

   // token payload holds between scans
   always_ff @(posedge clock) begin
      found_ff <= found_in;
      idx_ff   <= idx_in;
      best_ff  <= best_in;
   end

   assign next_valid = valid_ff;
   assign next_found = found_ff;
   assign next_idx   = idx_ff;
   assign next_size  = best_ff;

endmodule

@@ rtl/fixed_partition_fit_allocator_core.sv @@
// Top level of the fixed partition fit allocator: controller, cell chain, registers.
// Depends on fpfa_pkg, fpfa_if, fpfa_csr and fpfa_cell.
//
//   channel   direction  handshake            payload
//   req_bus   in         valid/ready          action, partition_index, amount
//   rsp_bus   out        valid/ready          outcome, chosen_index, chosen_size, fragment
//   csr       in         psel/penable/pready  fit_policy @0x0, partition_count @0x4
//
// A load's response is registered in the finish step after its transaction, and the next
// transaction is taken once the controller is back in idle. A request's response is registered
// once the search token has walked the chain one cell per clock, through all PARTITIONS cells.
// The response register lets the next transaction be accepted while a response waits; while
// it is still full and not being taken, the controller waits in its finish step.
// Synchronous reset clears all sizes and in-use marks at once; no clearing pass.

module fixed_partition_fit_allocator_core #(
   parameter int unsigned PARTITIONS = fpfa_pkg::PARTITIONS_DEF,
   parameter int unsigned SIZE_BITS  = fpfa_pkg::SIZE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   fpfa_req_if.sink                         req_bus,
   fpfa_rsp_if.source                       rsp_bus,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [fpfa_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [fpfa_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [fpfa_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);
   import fpfa_pkg::*;

   localparam int unsigned IDX_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;

   logic [POLICY_W-1:0] fit_policy;
   logic [COUNT_W-1:0]  partition_count;

   fsm_state_type state_ff, state_in;

   logic                 act_ff;
   logic [PINDEX_W-1:0]  pidx_ff;
   logic [SIZE_BITS-1:0] amt_ff, amt_in;
   logic [31:0]          amt_wide;
   logic                 start_ff, start_in;

   logic                 req_fire, finish_go;
   cell_cmd_type         cmd;

   logic                 chain_valid [PARTITIONS+1];
   logic                 chain_found [PARTITIONS+1];
   logic [IDX_W-1:0]     chain_idx   [PARTITIONS+1];
   logic [SIZE_BITS-1:0] chain_size  [PARTITIONS+1];

   logic                 out_valid_ff, out_valid_in;
   logic [OUTCOME_W-1:0] outcome_ff, outcome_in;
   logic [PINDEX_W-1:0]  cidx_ff, cidx_in;
   logic [AMOUNT_W-1:0]  csize_ff, csize_in;
   logic [AMOUNT_W-1:0]  frag_ff, frag_in;
   logic [31:0]          idx_wide, size_wide, frag_wide;
   logic [SIZE_BITS-1:0] frag_raw;

   fpfa_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .fit_policy      (fit_policy),
      .partition_count (partition_count)
   );

   assign req_fire = req_bus.valid && req_bus.ready;
   assign amt_wide = 32'(req_bus.amount);
   assign amt_in   = amt_wide[SIZE_BITS-1:0];
   assign start_in = req_fire && (req_bus.action == ACT_REQUEST);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_bus.action == ACT_REQUEST) ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            if (chain_valid[PARTITIONS]) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // controller outputs
   always_comb begin
      req_bus.ready = 1'b0;
      finish_go     = 1'b0;
      cmd           = '0;
      case (state_ff)
         ST_IDLE: req_bus.ready = 1'b1;
         ST_FINISH: begin
            finish_go   = !out_valid_ff || rsp_bus.ready;
            cmd.load_en = finish_go && (act_ff == ACT_LOAD);
            cmd.mark_en = finish_go && (act_ff == ACT_REQUEST) && chain_found[PARTITIONS];
         end
         default: req_bus.ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff  <= req_bus.action;
         pidx_ff <= req_bus.partition_index;
         amt_ff  <= amt_in;
      end
   end

   // search token enters cell 0 in the cycle after the request transaction
   assign chain_valid[0] = start_ff;
   assign chain_found[0] = 1'b0;
   assign chain_idx[0]   = '0;
   assign chain_size[0]  = '0;

   for (genvar g = 0; g < PARTITIONS; g++) begin : g_cell
      fpfa_cell #(
         .CELL_ID   (g),
         .IDX_W     (IDX_W),
         .SIZE_BITS (SIZE_BITS)
      ) u_cell (
         .clock           (clock),
         .reset           (reset),
         .cmd             (cmd),
         .load_index      (pidx_ff),
         .mark_index      (chain_idx[PARTITIONS]),
         .amount          (amt_ff),
         .fit_policy      (fit_policy),
         .partition_count (partition_count),
         .prev_valid      (chain_valid[g]),
         .prev_found      (chain_found[g]),
         .prev_idx        (chain_idx[g]),
         .prev_size       (chain_size[g]),
         .next_valid      (chain_valid[g+1]),
         .next_found      (chain_found[g+1]),
         .next_idx        (chain_idx[g+1]),
         .next_size       (chain_size[g+1])
      );
   end

   // response register
   assign idx_wide  = 32'(chain_idx[PARTITIONS]);
   assign size_wide = 32'(chain_size[PARTITIONS]);
   assign frag_raw  = chain_size[PARTITIONS] - amt_ff;
   assign frag_wide = 32'(frag_raw);

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      outcome_in   = outcome_ff;
      cidx_in      = cidx_ff;
      csize_in     = csize_ff;
      frag_in      = frag_ff;
      if (finish_go) begin
         out_valid_in = 1'b1;
         cidx_in      = '0;
         csize_in     = '0;
         frag_in      = '0;
         if (act_ff == ACT_LOAD) begin
            outcome_in = OUT_LOADED;
         end else if (chain_found[PARTITIONS]) begin
            outcome_in = OUT_ALLOCATED;
            cidx_in    = idx_wide[PINDEX_W-1:0];
            csize_in   = size_wide[AMOUNT_W-1:0];
            frag_in    = frag_wide[AMOUNT_W-1:0];
         end else begin
            outcome_in = OUT_UNALLOCATED;
         end
      end
   end

   always_ff @(posedge clock) begin
      outcome_ff <= outcome_in;
      cidx_ff    <= cidx_in;
      csize_ff   <= csize_in;
      frag_ff    <= frag_in;
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.outcome      = outcome_ff;
   assign rsp_bus.chosen_index = cidx_ff;
   assign rsp_bus.chosen_size  = csize_ff;
   assign rsp_bus.fragment     = frag_ff;

endmodule
